### src/nws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_pkg
// Shared constants and types for the nearest waypoint search block.
// ----------------------------------------------------------------------------
package nws_pkg;

  // table geometry and coordinate format
  localparam int MAX_POINTS   = 16;
  localparam int COORD_BITS   = 24;
  localparam int IDX_BITS     = $clog2(MAX_POINTS);
  localparam int ENTRY_BITS   = 2 * COORD_BITS;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int DIST_BITS    = SQ_BITS + 2;
  localparam int CFG_BITS     = 5;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((IDX_BITS + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((IDX_BITS + DIST_BITS + 7) / 8) * 8;

  // command carried on the input tuser
  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } nws_cmd_t;

  // query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } nws_state_t;

  // tag that travels with each table read through the distance pipeline
  typedef struct packed {
    logic                vld;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } nws_tag_t;

  // last table index scanned for a given entry count, count clamped to 1..MAX_POINTS
  function automatic logic [IDX_BITS-1:0] last_index(input logic [CFG_BITS-1:0] cnt);
    logic [IDX_BITS-1:0] res;
    if (cnt == '0) begin
      res = '0;
    end else if (32'(cnt) > MAX_POINTS) begin
      res = IDX_BITS'(MAX_POINTS - 1);
    end else begin
      res = IDX_BITS'(cnt - 1'b1);
    end
    return res;
  endfunction

endpackage

### src/nearest_waypoint_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_waypoint_search
// Waypoint table in RAM with a linear nearest-neighbour search by squared
// Euclidean distance; lowest index wins on ties.
// ----------------------------------------------------------------------------
// channel  direction  contents
// in_      slave      tuser: cmd; tdata: point_index, x_coord, y_coord
// out_     master     tdata: nearest_index, nearest_dist_sq (queries only)
// cfg_     write      points_in_use, no read-back
//
// A load is written to the table in the cycle it transfers; the block stays ready for the next item.
// A query reads one table entry per cycle from the RAM read port over the entries
// in use (points_in_use clamped to 1..16); each read passes the difference, square
// and running-minimum stages, and an output stall holds the finished result back.
// A new item is taken once the result has moved to the output register.
// Reset sets points_in_use to 1; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_waypoint_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [nws_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [nws_pkg::IN_DATA_BITS-1:0]   in_tdata,   // point_index, x_coord, y_coord, pad
  input  logic                               in_tuser,   // cmd
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [nws_pkg::OUT_DATA_BITS-1:0]  out_tdata   // nearest_index, nearest_dist_sq, pad
);
  import nws_pkg::*;

  nws_state_t state_r, state_nxt;

  logic [CFG_BITS-1:0]   cfg_count_r;
  logic [IDX_BITS-1:0]   last_r;
  logic [IDX_BITS-1:0]   rd_addr_r;
  logic [COORD_BITS-1:0] qx_r, qy_r;

  logic                  in_xfer;
  logic                  is_query;
  logic [IDX_BITS-1:0]   in_idx;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic                  wr_en;

  logic                  issue;
  logic                  issue_last;
  logic [ENTRY_BITS-1:0] rd_data;

  nws_tag_t              rd_tag_r, df_tag_r, sq_tag_r;
  logic [COORD_BITS-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [SQ_BITS-1:0]    dxsq_r, dysq_r;
  logic [DIST_BITS-1:0]  dist_sum;
  logic                  better;
  logic [DIST_BITS-1:0]  best_d_r;
  logic [IDX_BITS-1:0]   best_i_r;

  logic                     out_load;
  logic                     out_tvalid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  // input unpacking
  assign in_idx   = in_tdata[IDX_BITS-1:0];
  assign in_x     = in_tdata[IDX_BITS +: COORD_BITS];
  assign in_y     = in_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer  = in_tvalid & in_tready;
  assign is_query = (in_tuser == CMD_QUERY);
  assign wr_en    = in_xfer && (in_tuser == CMD_LOAD) &&
                    ({1'b0, in_idx} < (IDX_BITS + 1)'(MAX_POINTS));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= CFG_BITS'(1);
    end else if (cfg_wr_en) begin
      cfg_count_r <= cfg_wr_data;
    end
  end

  // waypoint table, entry is {y, x}
  nws_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_idx),
    .wr_data ({in_y, in_x}),
    .rd_en   (issue),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // read issue
  assign issue      = (state_r == ST_SCAN);
  assign issue_last = (rd_addr_r == last_r);

  // query capture and scan address
  always_ff @(posedge clk) begin
    if (in_xfer && is_query) begin
      qx_r      <= in_x;
      qy_r      <= in_y;
      last_r    <= last_index(cfg_count_r);
      rd_addr_r <= '0;
    end else if (issue && !issue_last) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end
  end

  // absolute coordinate differences
  always_comb begin
    logic signed [COORD_BITS:0] ddx, ddy;
    ddx = $signed({qx_r[COORD_BITS-1], qx_r}) -
          $signed({rd_data[COORD_BITS-1], rd_data[COORD_BITS-1:0]});
    ddy = $signed({qy_r[COORD_BITS-1], qy_r}) -
          $signed({rd_data[ENTRY_BITS-1], rd_data[ENTRY_BITS-1:COORD_BITS]});
    if (ddx[COORD_BITS]) ddx = -ddx;
    if (ddy[COORD_BITS]) ddy = -ddy;
    dx_nxt = ddx[COORD_BITS-1:0];
    dy_nxt = ddy[COORD_BITS-1:0];
  end

  // distance pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
      df_tag_r <= '0;
      sq_tag_r <= '0;
    end else begin
      rd_tag_r.vld  <= issue;
      rd_tag_r.last <= issue && issue_last;
      rd_tag_r.idx  <= rd_addr_r;
      df_tag_r      <= rd_tag_r;
      sq_tag_r      <= df_tag_r;
    end
  end

  // difference and square stages
  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dxsq_r <= dx_r * dx_r;
    dysq_r <= dy_r * dy_r;
  end

  // sum and running minimum, first entry always taken
  assign dist_sum = DIST_BITS'(dxsq_r) + DIST_BITS'(dysq_r);
  assign better   = (sq_tag_r.idx == '0) || (dist_sum < best_d_r);

  always_ff @(posedge clk) begin
    if (sq_tag_r.vld && better) begin
      best_d_r <= dist_sum;
      best_i_r <= sq_tag_r.idx;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_query) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sq_tag_r.vld && sq_tag_r.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_BITS'({best_d_r, best_i_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_rd_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rd_tag_r.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("table read data outside a query scan");

  a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_tag_r.vld && sq_tag_r.last) |=> (state_r == ST_DONE))
    else $error("last distance did not complete the query");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished query");

  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_addr_r <= last_r))
    else $error("scan address beyond entry count");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    sq_tag_r.vld |-> !in_tready)
    else $error("input taken while distance pipeline busy");

endmodule

### src/nws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### test/nearest_waypoint_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_waypoint_checker
// Watches the configuration port and both stream channels of the nearest
// waypoint search. Keeps its own copy of the waypoint table and the entry
// count, predicts the nearest index and squared distance for each query
// transfer, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module nearest_waypoint_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [nws_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [nws_pkg::IN_DATA_BITS-1:0]   in_tdata,   // point_index, x_coord, y_coord, pad
  input  logic                               in_tuser,   // cmd
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [nws_pkg::OUT_DATA_BITS-1:0]  out_tdata,  // nearest_index, nearest_dist_sq, pad
  output int                                 errors,
  output int                                 pending
);
  import nws_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  idx;
    logic [DIST_BITS-1:0] dist_sq;
  } nearest_t;

  localparam longint DIST_MAX = (64'd1 << DIST_BITS) - 1;

  // own copy of the table and the entry count
  coord_t                waypoint_x [MAX_POINTS];
  coord_t                waypoint_y [MAX_POINTS];
  logic [CFG_BITS-1:0]   points_in_use;
  nearest_t              expected_nearest [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // linear scan over the entries in use, lowest index kept on equal distance
  function automatic nearest_t nearest_waypoint(input coord_t qx, input coord_t qy);
    int       span;
    longint   dx;
    longint   dy;
    longint   d;
    longint   best_d;
    int       best_i;
    nearest_t res;
    span = int'(points_in_use);
    if (span == 0) begin
      span = 1;
    end else if (span > MAX_POINTS) begin
      span = MAX_POINTS;
    end
    best_i = 0;
    best_d = -1;
    for (int i = 0; i < span; i++) begin
      dx = longint'(qx) - longint'(waypoint_x[i]);
      dy = longint'(qy) - longint'(waypoint_y[i]);
      d  = dx * dx + dy * dy;
      if (best_d < 0 || d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    if (best_d > DIST_MAX) begin
      best_d = DIST_MAX;
    end
    res.idx     = IDX_BITS'(best_i);
    res.dist_sq = DIST_BITS'(best_d);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    nearest_t got;
    nearest_t want;
    if (!rst_n) begin
      points_in_use = CFG_BITS'(1);
      expected_nearest.delete();
    end else begin
      if (cfg_wr_en) begin
        points_in_use = cfg_wr_data;
      end

      // input transfer: a load updates the table, a query queues a prediction
      if (in_tvalid && in_tready) begin
        if (nws_cmd_t'(in_tuser) == CMD_LOAD) begin
          waypoint_x[in_tdata[IDX_BITS-1:0]] = in_tdata[IDX_BITS +: COORD_BITS];
          waypoint_y[in_tdata[IDX_BITS-1:0]] = in_tdata[IDX_BITS+COORD_BITS +: COORD_BITS];
        end else begin
          expected_nearest.push_back(nearest_waypoint(
            in_tdata[IDX_BITS +: COORD_BITS],
            in_tdata[IDX_BITS+COORD_BITS +: COORD_BITS]));
        end
      end

      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.idx     = out_tdata[IDX_BITS-1:0];
        got.dist_sq = out_tdata[IDX_BITS +: DIST_BITS];
        if (expected_nearest.size() == 0) begin
          report_mismatch("unexpected result, index", longint'(got.idx), -1);
        end else begin
          want = expected_nearest.pop_front();
          if (got.idx !== want.idx) begin
            report_mismatch("nearest_index", longint'(got.idx), longint'(want.idx));
          end
          if (got.dist_sq !== want.dist_sq) begin
            report_mismatch("nearest_dist_sq", longint'(got.dist_sq),
                            longint'(want.dist_sq));
          end
        end
      end
    end
    pending = expected_nearest.size();
  end

endmodule

### test/tb_nearest_waypoint_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_waypoint_search
// Drives loads and queries into the nearest waypoint search under several
// entry counts and idle patterns on both channels. Prediction and comparison
// sit in the checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_nearest_waypoint_search;
  import nws_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_BITS-1:0]       cfg_wr_data;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata;   // point_index, x_coord, y_coord, pad
  logic                      in_tuser;   // cmd
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_BITS-1:0]  out_tdata;  // nearest_index, nearest_dist_sq, pad

  int errors;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nearest_waypoint_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  nearest_waypoint_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .pending     (pending)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer, optional idle cycles first; ends on a falling edge
  // ready only changes at rising edges, so it is checked at the falling edge
  task automatic send_item(input nws_cmd_t cmd, input logic [IDX_BITS-1:0] idx,
                           input coord_t x, input coord_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_BITS'({y, x, idx});
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_point_count(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_BITS'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // let all queries come back, then wait on for a trailing load
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // extremes, small values for ties, and full-range values
  function automatic coord_t pick_coord();
    coord_t c;
    case ($urandom_range(9))
      0:       c = COORD_MIN;
      1:       c = COORD_MAX;
      2:       c = '0;
      3, 4:    c = coord_t'($urandom_range(6)) - coord_t'(3);
      default: c = coord_t'($urandom);
    endcase
    return c;
  endfunction

  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input int n_items);
    nws_cmd_t cmd;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_point_count(count);
    for (int i = 0; i < n_items; i++) begin
      cmd = ($urandom_range(99) < 35) ? CMD_LOAD : CMD_QUERY;
      send_item(cmd, IDX_BITS'($urandom), pick_coord(), pick_coord());
    end
    drain_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    out_tready    = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 87;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: fill every entry with corners, origin twins, unit neighbours and random points
    write_point_count(MAX_POINTS);
    send_item(CMD_LOAD, 4'd0, COORD_MIN, COORD_MIN);
    send_item(CMD_LOAD, 4'd1, COORD_MAX, COORD_MAX);
    send_item(CMD_LOAD, 4'd2, '0, '0);
    send_item(CMD_LOAD, 4'd3, COORD_MIN, COORD_MAX);
    send_item(CMD_LOAD, 4'd4, COORD_MAX, COORD_MIN);
    send_item(CMD_LOAD, 4'd5, '0, '0);
    send_item(CMD_LOAD, 4'd6, coord_t'(1), -coord_t'(1));
    send_item(CMD_LOAD, 4'd7, -coord_t'(1), coord_t'(1));
    for (int i = 8; i < MAX_POINTS; i++) begin
      send_item(CMD_LOAD, IDX_BITS'(i), coord_t'($urandom), coord_t'($urandom));
    end
    send_item(CMD_QUERY, 4'd0, COORD_MAX, COORD_MAX);
    send_item(CMD_QUERY, 4'd15, COORD_MIN, COORD_MIN);
    // equal distance to both origin entries; the two unit neighbours lie just beyond
    send_item(CMD_QUERY, 4'd9, '0, '0);
    send_item(CMD_QUERY, 4'd0, COORD_MAX, COORD_MIN);
    send_item(CMD_QUERY, 4'd6, COORD_MIN, COORD_MAX);
    send_item(CMD_QUERY, 4'd0, coord_t'(1), coord_t'(1));
    drain_results();

    // single entry: opposite corner gives the largest distance
    write_point_count(1);
    send_item(CMD_QUERY, 4'd0, COORD_MAX, COORD_MAX);
    drain_results();

    // random phases: count setting and idle pattern per phase
    run_phase(1, 16, 87, 72);
    run_phase(0, 16, 87, 72);
    run_phase(31, 87, 16, 72);
    run_phase(17, 87, 16, 72);
    run_phase(int'($urandom_range(15, 2)), 0, 0, 72);
    run_phase(MAX_POINTS, 0, 0, 72);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
src/nws_pkg.sv
src/nws_ram.sv
src/nearest_waypoint_search.sv
test/nearest_waypoint_checker.sv
test/tb_nearest_waypoint_search.sv
